/* design/mped_pkg.sv */
// ----------------------------------------------------------------------------
// mped_pkg
// Shared types and constants for the mouse packet event decoder.
// ----------------------------------------------------------------------------
package mped_pkg;

    localparam int COORD_BITS    = 12;
    localparam int TICK_BITS     = 32;
    localparam int BOUND_BITS    = 13;
    localparam int POS_BITS      = 12;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 48;
    localparam int NUM_SLOTS     = 9;
    localparam int SLOT_IDX_BITS = 4;

    localparam int LIM_W  = (BOUND_BITS > COORD_BITS + 1) ? BOUND_BITS : COORD_BITS + 1;
    localparam int SLOP_W = (BOUND_BITS > COORD_BITS) ? BOUND_BITS : COORD_BITS;

    localparam logic [7:0] SYNC_BIT    = 8'h08;
    localparam logic [7:0] BUTTON_BITS = 8'h07;

    // register indexes on the config port
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WHEEL_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BOUND_X      = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BOUND_Y      = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DBL_WINDOW   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DBL_SLOP_X   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DBL_SLOP_Y   = 3'd5;

    localparam logic [BOUND_BITS-1:0]    BOUND_X_RESET    = 13'd1024;
    localparam logic [BOUND_BITS-1:0]    BOUND_Y_RESET    = 13'd768;
    localparam logic [CFG_DATA_BITS-1:0] DBL_WINDOW_RESET = 32'd30;
    localparam logic [BOUND_BITS-1:0]    DBL_SLOP_X_RESET = 13'd8;
    localparam logic [BOUND_BITS-1:0]    DBL_SLOP_Y_RESET = 13'd16;

    localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'(384);

    // event slots, in the order they are delivered
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_PRESS0  = 4'd0;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_DBL     = 4'd1;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_REL0    = 4'd2;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_PRESS1  = 4'd3;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_REL1    = 4'd4;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_PRESS2  = 4'd5;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_REL2    = 4'd6;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_SCROLL  = 4'd7;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_MOTION  = 4'd8;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_DBL     = 3'd2,
        EV_SCROLL  = 3'd3,
        EV_DRAG    = 3'd4,
        EV_MOVE    = 3'd5
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2,
        PH_WHEEL  = 2'd3
    } phase_t;

    typedef struct packed {
        logic                     wheel_enable;
        logic [BOUND_BITS-1:0]    bound_x;
        logic [BOUND_BITS-1:0]    bound_y;
        logic [CFG_DATA_BITS-1:0] dbl_window;
        logic [BOUND_BITS-1:0]    dbl_slop_x;
        logic [BOUND_BITS-1:0]    dbl_slop_y;
    } cfg_t;

    // one decoded packet: pending event slots plus shared payload
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic signed [7:0]    dx;
        logic signed [8:0]    dy;
        logic signed [7:0]    scroll;
        logic [2:0]           buttons;
        logic [POS_BITS-1:0]  pos_x;
        logic [POS_BITS-1:0]  pos_y;
    } pkt_t;

endpackage

/* design/mped_decode.sv */
// ----------------------------------------------------------------------------
// mped_decode
// Packet assembly, cursor update with clamping and double-click detection.
// ----------------------------------------------------------------------------
module mped_decode import mped_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_acc,
    input  logic       in_func,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output logic       pkt_load,
    output pkt_t       pkt
);

    phase_t                  phase_reg;
    logic [7:0]              header_reg;
    logic [7:0]              move_x_reg;
    logic [7:0]              move_y_reg;
    logic [2:0]              prior_reg;
    logic [COORD_BITS-1:0]   cursor_x_reg;
    logic [COORD_BITS-1:0]   cursor_y_reg;
    logic [TICK_BITS-1:0]    tick_reg;
    logic [TICK_BITS-1:0]    click_tick_reg;
    logic [COORD_BITS-1:0]   click_x_reg;
    logic [COORD_BITS-1:0]   click_y_reg;

    logic [7:0]              y_byte;
    logic signed [7:0]       dx;
    logic signed [8:0]       dy;
    logic signed [7:0]       scroll;
    logic [2:0]              nb;
    logic [2:0]              pressed;
    logic [2:0]              released;
    logic [COORD_BITS-1:0]   cursor_x_next;
    logic [COORD_BITS-1:0]   cursor_y_next;
    logic [COORD_BITS-1:0]   dist_x;
    logic [COORD_BITS-1:0]   dist_y;
    logic [TICK_BITS-1:0]    elapsed;
    logic                    dbl_hit;
    logic                    complete;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic signed [8:0]     d,
        input logic [BOUND_BITS-1:0] bound
    );
        logic [LIM_W-1:0]             bw;
        logic [COORD_BITS-1:0]        lim;
        logic signed [COORD_BITS+1:0] p;
        bw = LIM_W'(bound);
        if (bw == '0) begin
            lim = '0;
        end else if (bw > (LIM_W'(1) << COORD_BITS)) begin
            lim = '1;
        end else begin
            lim = COORD_BITS'(bw - LIM_W'(1));
        end
        p = $signed({2'b00, pos}) + (COORD_BITS+2)'(d);
        if (p < 0) begin
            clamp_axis = '0;
        end else if (p > $signed({2'b00, lim})) begin
            clamp_axis = lim;
        end else begin
            clamp_axis = p[COORD_BITS-1:0];
        end
    endfunction

    assign complete = in_acc && !in_func &&
                      ((phase_reg == PH_Y && !cfg.wheel_enable) || phase_reg == PH_WHEEL);

    // y byte arrives with the current transaction when there is no wheel byte
    assign y_byte   = (phase_reg == PH_Y) ? in_byte : move_y_reg;
    assign dx       = $signed(move_x_reg);
    assign dy       = -$signed({y_byte[7], y_byte});
    assign scroll   = (phase_reg == PH_WHEEL && cfg.wheel_enable) ? $signed(in_byte) : 8'sd0;
    assign nb       = header_reg[2:0] & BUTTON_BITS[2:0];
    assign pressed  = nb & ~prior_reg;
    assign released = prior_reg & ~nb;

    assign cursor_x_next = clamp_axis(cursor_x_reg, {dx[7], dx}, cfg.bound_x);
    assign cursor_y_next = clamp_axis(cursor_y_reg, dy, cfg.bound_y);

    assign dist_x  = (cursor_x_next > click_x_reg) ? cursor_x_next - click_x_reg
                                                   : click_x_reg - cursor_x_next;
    assign dist_y  = (cursor_y_next > click_y_reg) ? cursor_y_next - click_y_reg
                                                   : click_y_reg - cursor_y_next;
    assign elapsed = tick_reg - click_tick_reg;

    assign dbl_hit = pressed[0] &&
                     (CFG_DATA_BITS'(elapsed) < cfg.dbl_window) &&
                     (SLOP_W'(dist_x) < SLOP_W'(cfg.dbl_slop_x)) &&
                     (SLOP_W'(dist_y) < SLOP_W'(cfg.dbl_slop_y));

    always_comb begin
        pkt.slots              = '0;
        pkt.slots[SLOT_PRESS0] = pressed[0];
        pkt.slots[SLOT_DBL]    = dbl_hit;
        pkt.slots[SLOT_REL0]   = released[0];
        pkt.slots[SLOT_PRESS1] = pressed[1];
        pkt.slots[SLOT_REL1]   = released[1];
        pkt.slots[SLOT_PRESS2] = pressed[2];
        pkt.slots[SLOT_REL2]   = released[2];
        pkt.slots[SLOT_SCROLL] = (scroll != 8'sd0);
        pkt.slots[SLOT_MOTION] = (dx != 8'sd0) || (dy != 9'sd0);
        pkt.dx                 = dx;
        pkt.dy                 = dy;
        pkt.scroll             = scroll;
        pkt.buttons            = nb;
        pkt.pos_x              = POS_BITS'(cursor_x_next);
        pkt.pos_y              = POS_BITS'(cursor_y_next);
    end

    assign pkt_load = complete;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            header_reg     <= '0;
            move_x_reg     <= '0;
            move_y_reg     <= '0;
            prior_reg      <= '0;
            cursor_x_reg   <= CURSOR_X_RESET;
            cursor_y_reg   <= CURSOR_Y_RESET;
            tick_reg       <= '0;
            click_tick_reg <= '0;
            click_x_reg    <= '0;
            click_y_reg    <= '0;
        end else if (in_acc) begin
            if (in_func) begin
                tick_reg <= tick_reg + TICK_BITS'(1);
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        // drop bytes without the sync bit to regain alignment
                        if ((in_byte & SYNC_BIT) != 8'h00) begin
                            header_reg <= in_byte;
                            phase_reg  <= PH_X;
                        end
                    end
                    PH_X: begin
                        move_x_reg <= in_byte;
                        phase_reg  <= PH_Y;
                    end
                    PH_Y: begin
                        move_y_reg <= in_byte;
                        phase_reg  <= cfg.wheel_enable ? PH_WHEEL : PH_HEADER;
                    end
                    PH_WHEEL: begin
                        phase_reg <= PH_HEADER;
                    end
                endcase
                if (complete) begin
                    cursor_x_reg <= cursor_x_next;
                    cursor_y_reg <= cursor_y_next;
                    prior_reg    <= nb;
                    if (pressed[0]) begin
                        if (dbl_hit) begin
                            click_tick_reg <= '0;
                        end else begin
                            click_tick_reg <= tick_reg;
                            click_x_reg    <= cursor_x_next;
                            click_y_reg    <= cursor_y_next;
                        end
                    end
                end
            end
        end
    end

endmodule

/* design/mouse_packet_event_decoder_core.sv */
// ----------------------------------------------------------------------------
// mouse_packet_event_decoder_core
// Mouse byte stream to press, release, double-click, scroll and motion events.
// ----------------------------------------------------------------------------
// m_tvalid rises with a packet's first event after the transaction with its last
// byte fills the pending-event register and then the output register. Events go
// out at one per cycle unless the output stalls; the input is held until the
// last pending event is loaded. Reset is synchronous on aresetn and returns
// parser, cursor, click history and config registers to defaults.
module mouse_packet_event_decoder_core import mped_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // data_byte
    input  logic [0:0]               s_tuser,   // func
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // button_mask, pos_x, pos_y, delta_x, delta_y, buttons_now, zero pad
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic [2:0]               m_tuser,   // event_kind
    output logic                     m_tlast,   // last_of_run
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t                     cfg_reg;
    logic [NUM_SLOTS-1:0]     slot_reg;
    pkt_t                     pkt_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    event_kind_t              m_kind_reg;
    logic                     m_tlast_reg;

    logic                     s_acc;
    logic                     pkt_load;
    pkt_t                     pkt_new;
    logic                     load_out;
    logic [SLOT_IDX_BITS-1:0] slot_idx;
    logic [NUM_SLOTS-1:0]     slot_next;
    event_kind_t              ev_kind;
    logic [2:0]               ev_mask;
    logic signed [7:0]        ev_dx;
    logic signed [8:0]        ev_dy;
    logic [2:0]               ev_btn;

    mped_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_acc   (s_acc),
        .in_func  (s_tuser[0]),
        .in_byte  (s_tdata),
        .cfg      (cfg_reg),
        .pkt_load (pkt_load),
        .pkt      (pkt_new)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_enable <= 1'b0;
            cfg_reg.bound_x      <= BOUND_X_RESET;
            cfg_reg.bound_y      <= BOUND_Y_RESET;
            cfg_reg.dbl_window   <= DBL_WINDOW_RESET;
            cfg_reg.dbl_slop_x   <= DBL_SLOP_X_RESET;
            cfg_reg.dbl_slop_y   <= DBL_SLOP_Y_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WHEEL_ENABLE: cfg_reg.wheel_enable <= cfg_wdata[0];
                CFG_BOUND_X:      cfg_reg.bound_x      <= cfg_wdata[BOUND_BITS-1:0];
                CFG_BOUND_Y:      cfg_reg.bound_y      <= cfg_wdata[BOUND_BITS-1:0];
                CFG_DBL_WINDOW:   cfg_reg.dbl_window   <= cfg_wdata;
                CFG_DBL_SLOP_X:   cfg_reg.dbl_slop_x   <= cfg_wdata[BOUND_BITS-1:0];
                CFG_DBL_SLOP_Y:   cfg_reg.dbl_slop_y   <= cfg_wdata[BOUND_BITS-1:0];
                default: ;
            endcase
        end
    end

    // lowest pending slot goes out first
    always_comb begin
        slot_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_reg[i]) begin
                slot_idx = SLOT_IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        slot_next           = slot_reg;
        slot_next[slot_idx] = 1'b0;
    end

    assign load_out = (slot_reg != '0) && (!m_tvalid_reg || m_tready);
    assign s_tready = (slot_reg == '0) || (load_out && slot_next == '0);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        ev_kind = EV_MOVE;
        ev_mask = 3'b000;
        ev_dx   = pkt_reg.dx;
        ev_dy   = pkt_reg.dy;
        ev_btn  = pkt_reg.buttons;
        unique case (slot_idx)
            SLOT_PRESS0: begin
                ev_kind = EV_PRESS;
                ev_mask = 3'b001;
            end
            SLOT_DBL: begin
                ev_kind = EV_DBL;
                ev_mask = 3'b001;
                ev_dx   = 8'sd0;
                ev_dy   = 9'sd0;
            end
            SLOT_REL0: begin
                ev_kind = EV_RELEASE;
                ev_mask = 3'b001;
            end
            SLOT_PRESS1: begin
                ev_kind = EV_PRESS;
                ev_mask = 3'b010;
            end
            SLOT_REL1: begin
                ev_kind = EV_RELEASE;
                ev_mask = 3'b010;
            end
            SLOT_PRESS2: begin
                ev_kind = EV_PRESS;
                ev_mask = 3'b100;
            end
            SLOT_REL2: begin
                ev_kind = EV_RELEASE;
                ev_mask = 3'b100;
            end
            SLOT_SCROLL: begin
                ev_kind = EV_SCROLL;
                ev_dx   = 8'sd0;
                ev_dy   = 9'(pkt_reg.scroll);
            end
            SLOT_MOTION: begin
                if (pkt_reg.buttons != 3'b000) begin
                    ev_kind = EV_DRAG;
                    ev_mask = pkt_reg.buttons;
                end else begin
                    ev_kind = EV_MOVE;
                    ev_btn  = 3'b000;
                end
            end
            default: ;
        endcase
    end

    // pending-event register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (s_acc && pkt_load) begin
            slot_reg <= pkt_new.slots;
        end else if (load_out) begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && pkt_load) begin
            pkt_reg <= pkt_new;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {1'b0, ev_btn, ev_dy, ev_dx, pkt_reg.pos_y, pkt_reg.pos_x, ev_mask};
            m_kind_reg  <= ev_kind;
            m_tlast_reg <= (slot_next == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // a packet never schedules more than six events
    a_slot_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_reg) <= 6)
        else $error("too many pending events");

    // a stalled output must not consume pending events
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && slot_reg != '0 |=> $stable(slot_reg))
        else $error("pending events changed during output stall");

    // with nothing pending the input side is open
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg == '0 |-> s_tready)
        else $error("input blocked with no pending events");

    // move events carry no button state
    a_move_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_MOVE |-> m_tdata[46:44] == 3'b000 && m_tdata[2:0] == 3'b000)
        else $error("move event with button bits");
`endif

endmodule
